[src/rrts_pkg.sv]
// Shared types and codes for the round-robin thread scheduler.
// No dependencies; used by rrts_front, rrts_back and the top level.
package rrts_pkg;

	// request codes as they arrive on req_type
	localparam logic [3:0] REQ_ADD    = 4'd0;
	localparam logic [3:0] REQ_START  = 4'd1;
	localparam logic [3:0] REQ_YIELD  = 4'd2;
	localparam logic [3:0] REQ_YPEND  = 4'd3;
	localparam logic [3:0] REQ_BLOCK  = 4'd4;
	localparam logic [3:0] REQ_WAKE   = 4'd5;
	localparam logic [3:0] REQ_SLEEP  = 4'd6;
	localparam logic [3:0] REQ_FINISH = 4'd7;
	localparam logic [3:0] REQ_TICK   = 4'd8;

	// thread states held in the state table
	localparam logic [1:0] TS_WAITING  = 2'd0;
	localparam logic [1:0] TS_ACTIVE   = 2'd1;
	localparam logic [1:0] TS_BLOCKED  = 2'd2;
	localparam logic [1:0] TS_FINISHED = 2'd3;

	// result status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	typedef enum logic [3:0] {
		OP_ADD,
		OP_START,
		OP_YIELD,
		OP_YPEND,
		OP_BLOCK,
		OP_WAKE,
		OP_SLEEP,
		OP_FINISH,
		OP_TICK,
		OP_BAD
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        in_range;
		logic [3:0]  idx;
		logic [31:0] ticks;
	} cmd_t;

	typedef struct packed {
		logic [3:0] current_index;
		logic       idle_running;
		logic       switched;
		logic       reschedule_pending;
		logic [3:0] added_index;
		logic [1:0] status;
	} res_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WAKE_CHK,
		B_SCAN,
		B_YUPD_OLD,
		B_YUPD_NEW,
		B_DONE
	} bstate_t;

endpackage

[src/rrts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/rrts_front.sv]
// Front end: accepts requests, decodes them into commands and holds them
// in a two-entry queue for the back end. Depends on rrts_pkg.
module rrts_front #(
	parameter int MAX_THREADS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [3:0]         req_type,
	input  logic [3:0]         thread_index,
	input  logic [31:0]        sleep_ticks,
	output logic               cmd_valid,
	output rrts_pkg::cmd_t     cmd,
	input  logic               cmd_pop
);

	localparam int AW = $clog2(MAX_THREADS);
	localparam logic [1:0] QDEPTH = 2'd2;

	rrts_pkg::cmd_t  dec;
	rrts_pkg::cmd_t  mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic [AW+3:0]   idx_w;
	logic            do_push;
	logic            do_pop;

	assign idx_w = {{AW{1'b0}}, thread_index};

	always_comb begin
		dec.in_range = idx_w < (AW+4)'(MAX_THREADS);
		dec.idx      = thread_index;
		dec.ticks    = sleep_ticks;
		case (req_type)
			rrts_pkg::REQ_ADD:    dec.op = rrts_pkg::OP_ADD;
			rrts_pkg::REQ_START:  dec.op = rrts_pkg::OP_START;
			rrts_pkg::REQ_YIELD:  dec.op = rrts_pkg::OP_YIELD;
			rrts_pkg::REQ_YPEND:  dec.op = rrts_pkg::OP_YPEND;
			rrts_pkg::REQ_BLOCK:  dec.op = rrts_pkg::OP_BLOCK;
			rrts_pkg::REQ_WAKE:   dec.op = rrts_pkg::OP_WAKE;
			rrts_pkg::REQ_SLEEP:  dec.op = rrts_pkg::OP_SLEEP;
			rrts_pkg::REQ_FINISH: dec.op = rrts_pkg::OP_FINISH;
			rrts_pkg::REQ_TICK:   dec.op = rrts_pkg::OP_TICK;
			default:              dec.op = rrts_pkg::OP_BAD;
		endcase
	end

	assign full      = cnt_q == QDEPTH;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

[src/rrts_back.sv]
// Back end: sequencer that carries out commands against the thread state
// and wake time tables and fills the result register.
// Depends on rrts_pkg and rrts_ram.
module rrts_back #(
	parameter int MAX_THREADS = 16,
	parameter int TICK_BITS   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  rrts_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output logic               res_valid,
	output rrts_pkg::res_t     res,
	input  logic               res_pop
);

	localparam int AW = $clog2(MAX_THREADS);
	localparam int CW = $clog2(MAX_THREADS + 1);
	localparam int TB = TICK_BITS;

	rrts_pkg::bstate_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] running_q, running_d;
	logic          on_idle_q, on_idle_d;
	logic          started_q, started_d;
	logic          resched_q, resched_d;
	logic [TB-1:0] tick_q, tick_d;

	logic          tick_scan_q, tick_scan_d;
	logic [AW-1:0] tgt_q, tgt_d;
	logic [AW-1:0] scan_addr_q, scan_addr_d;
	logic [CW-1:0] scan_cnt_q, scan_cnt_d;
	logic          rd_vld_s1, rd_vld_d;
	logic [AW-1:0] rd_addr_s1, rd_addr_d;
	logic          found_q, found_d;
	logic [AW-1:0] pick_q, pick_d;
	logic [AW-1:0] old_q, old_d;
	logic          was_idle_q, was_idle_d;
	logic          old_act_q, old_act_d;
	logic          sw_q, sw_d;
	logic [3:0]    added_q, added_d;
	logic [1:0]    status_q, status_d;

	logic           res_valid_q;
	rrts_pkg::res_t res_q;
	logic           res_load;

	logic          st_we;
	logic [AW-1:0] st_waddr;
	logic [1:0]    st_wdata;
	logic [1:0]    st_rdata;
	logic          wk_we;
	logic [AW-1:0] wk_waddr;
	logic [TB-1:0] wk_wdata;
	logic [TB-1:0] wk_rdata;
	logic [AW-1:0] raddr;

	logic [AW+3:0] idx_w;
	logic [AW-1:0] tgt_idx;
	logic          tgt_ok;
	logic [AW+3:0] cnt_w;
	logic [AW+3:0] run_w;
	logic [TB+31:0] ticks_w;
	logic [TB-1:0] wake_sum;
	logic [AW-1:0] first_addr;
	logic          yield_go;
	logic          tick_go;
	logic          rd_used;

	rrts_ram #(.WIDTH(2), .DEPTH(MAX_THREADS)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (raddr),
		.rdata (st_rdata)
	);

	rrts_ram #(.WIDTH(TB), .DEPTH(MAX_THREADS)) u_wake_ram (
		.clk   (clk),
		.we    (wk_we),
		.waddr (wk_waddr),
		.wdata (wk_wdata),
		.raddr (raddr),
		.rdata (wk_rdata)
	);

	// entries are handed out in order, so an entry is in use below the count
	assign idx_w    = {{AW{1'b0}}, cmd.idx};
	assign tgt_idx  = idx_w[AW-1:0];
	assign tgt_ok   = cmd.in_range && (CW'(tgt_idx) < count_q);
	assign cnt_w    = {4'b0, count_q[AW-1:0]};
	assign run_w    = {4'b0, running_q};
	assign ticks_w  = {{TB{1'b0}}, cmd.ticks};
	assign wake_sum = tick_q + ticks_w[TB-1:0];
	assign rd_used  = CW'(rd_addr_s1) < count_q;

	assign first_addr = on_idle_q ? '0 :
		((running_q == AW'(MAX_THREADS - 1)) ? '0 : running_q + AW'(1));

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		running_d    = running_q;
		on_idle_d    = on_idle_q;
		started_d    = started_q;
		resched_d    = resched_q;
		tick_d       = tick_q;
		tick_scan_d  = tick_scan_q;
		tgt_d        = tgt_q;
		scan_addr_d  = scan_addr_q;
		scan_cnt_d   = scan_cnt_q;
		rd_vld_d     = 1'b0;
		rd_addr_d    = rd_addr_s1;
		found_d      = found_q;
		pick_d       = pick_q;
		old_d        = old_q;
		was_idle_d   = was_idle_q;
		old_act_d    = old_act_q;
		sw_d         = sw_q;
		added_d      = added_q;
		status_d     = status_q;
		cmd_pop      = 1'b0;
		res_load     = 1'b0;
		st_we        = 1'b0;
		st_waddr     = '0;
		st_wdata     = rrts_pkg::TS_WAITING;
		wk_we        = 1'b0;
		wk_waddr     = '0;
		wk_wdata     = '0;
		raddr        = scan_addr_q;
		yield_go     = 1'b0;
		tick_go      = 1'b0;

		case (state_q)
			rrts_pkg::B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop  = 1'b1;
					sw_d     = 1'b0;
					added_d  = 4'd0;
					status_d = rrts_pkg::STAT_OK;
					state_d  = rrts_pkg::B_DONE;
					case (cmd.op)
						rrts_pkg::OP_ADD: begin
							if (count_q == CW'(MAX_THREADS)) begin
								status_d = rrts_pkg::STAT_FULL;
							end else begin
								st_we    = 1'b1;
								st_waddr = count_q[AW-1:0];
								st_wdata = rrts_pkg::TS_WAITING;
								wk_we    = 1'b1;
								wk_waddr = count_q[AW-1:0];
								wk_wdata = '0;
								count_d  = count_q + CW'(1);
								added_d  = cnt_w[3:0];
							end
						end
						rrts_pkg::OP_START: begin
							if (started_q || count_q == '0) begin
								status_d = rrts_pkg::STAT_BAD;
							end else begin
								started_d = 1'b1;
								running_d = '0;
								on_idle_d = 1'b0;
								st_we     = 1'b1;
								st_waddr  = '0;
								st_wdata  = rrts_pkg::TS_ACTIVE;
								sw_d      = 1'b1;
							end
						end
						rrts_pkg::OP_YIELD: begin
							if (!started_q) begin
								status_d = rrts_pkg::STAT_BAD;
							end else begin
								yield_go = 1'b1;
							end
						end
						rrts_pkg::OP_YPEND: begin
							if (!resched_q) begin
								status_d = rrts_pkg::STAT_BAD;
							end else begin
								resched_d = 1'b0;
								yield_go  = started_q;
							end
						end
						rrts_pkg::OP_BLOCK: begin
							if (!tgt_ok) begin
								status_d = rrts_pkg::STAT_BAD;
							end else begin
								st_we    = 1'b1;
								st_waddr = tgt_idx;
								st_wdata = rrts_pkg::TS_BLOCKED;
								yield_go = started_q;
							end
						end
						rrts_pkg::OP_WAKE: begin
							if (!tgt_ok) begin
								status_d = rrts_pkg::STAT_BAD;
							end else begin
								raddr   = tgt_idx;
								tgt_d   = tgt_idx;
								state_d = rrts_pkg::B_WAKE_CHK;
							end
						end
						rrts_pkg::OP_SLEEP, rrts_pkg::OP_FINISH: begin
							if (!started_q || on_idle_q) begin
								status_d = rrts_pkg::STAT_BAD;
							end else begin
								st_we    = 1'b1;
								st_waddr = running_q;
								if (cmd.op == rrts_pkg::OP_SLEEP) begin
									st_wdata = rrts_pkg::TS_BLOCKED;
									wk_we    = 1'b1;
									wk_waddr = running_q;
									wk_wdata = wake_sum;
								end else begin
									st_wdata = rrts_pkg::TS_FINISHED;
								end
								yield_go = 1'b1;
							end
						end
						rrts_pkg::OP_TICK: begin
							tick_d  = tick_q + TB'(1);
							tick_go = 1'b1;
						end
						default: begin
							status_d = rrts_pkg::STAT_BAD;
						end
					endcase
				end
			end

			rrts_pkg::B_WAKE_CHK: begin
				if (st_rdata == rrts_pkg::TS_BLOCKED) begin
					st_we    = 1'b1;
					st_waddr = tgt_q;
					st_wdata = rrts_pkg::TS_WAITING;
				end else begin
					status_d = rrts_pkg::STAT_BAD;
				end
				state_d = rrts_pkg::B_DONE;
			end

			rrts_pkg::B_SCAN: begin
				// issue one read a cycle; the returned entry is handled in the next cycle
				if (scan_cnt_q != CW'(MAX_THREADS)) begin
					raddr       = scan_addr_q;
					rd_vld_d    = 1'b1;
					rd_addr_d   = scan_addr_q;
					scan_cnt_d  = scan_cnt_q + CW'(1);
					scan_addr_d = (scan_addr_q == AW'(MAX_THREADS - 1)) ? '0 :
						scan_addr_q + AW'(1);
				end
				if (rd_vld_s1) begin
					if (tick_scan_q) begin
						if (rd_used && st_rdata == rrts_pkg::TS_BLOCKED &&
							wk_rdata != '0 && tick_q >= wk_rdata) begin
							st_we     = 1'b1;
							st_waddr  = rd_addr_s1;
							st_wdata  = rrts_pkg::TS_WAITING;
							wk_we     = 1'b1;
							wk_waddr  = rd_addr_s1;
							wk_wdata  = '0;
							resched_d = 1'b1;
						end
					end else begin
						if (rd_used && st_rdata == rrts_pkg::TS_WAITING && !found_q) begin
							found_d = 1'b1;
							pick_d  = rd_addr_s1;
						end
						if (rd_addr_s1 == old_q && st_rdata == rrts_pkg::TS_ACTIVE) begin
							old_act_d = 1'b1;
						end
					end
				end
				if (scan_cnt_q == CW'(MAX_THREADS) && !rd_vld_s1) begin
					state_d = tick_scan_q ? rrts_pkg::B_DONE : rrts_pkg::B_YUPD_OLD;
				end
			end

			rrts_pkg::B_YUPD_OLD: begin
				// a yielding active thread goes back to waiting
				if (!was_idle_q && old_act_q) begin
					st_we    = 1'b1;
					st_waddr = old_q;
					st_wdata = rrts_pkg::TS_WAITING;
				end
				state_d = rrts_pkg::B_YUPD_NEW;
			end

			rrts_pkg::B_YUPD_NEW: begin
				if (found_q) begin
					st_we     = 1'b1;
					st_waddr  = pick_q;
					st_wdata  = rrts_pkg::TS_ACTIVE;
					running_d = pick_q;
					on_idle_d = 1'b0;
					sw_d      = was_idle_q || (pick_q != old_q);
				end else begin
					on_idle_d = 1'b1;
					sw_d      = !was_idle_q;
				end
				state_d = rrts_pkg::B_DONE;
			end

			rrts_pkg::B_DONE: begin
				if (!res_valid_q || res_pop) begin
					res_load = 1'b1;
					state_d  = rrts_pkg::B_IDLE;
				end
			end

			default: begin
				state_d = rrts_pkg::B_IDLE;
			end
		endcase

		if (yield_go) begin
			scan_addr_d = first_addr;
			scan_cnt_d  = '0;
			found_d     = 1'b0;
			old_act_d   = 1'b0;
			was_idle_d  = on_idle_q;
			old_d       = running_q;
			tick_scan_d = 1'b0;
			state_d     = rrts_pkg::B_SCAN;
		end
		if (tick_go) begin
			scan_addr_d = '0;
			scan_cnt_d  = '0;
			tick_scan_d = 1'b1;
			state_d     = rrts_pkg::B_SCAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrts_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			running_q   <= '0;
			on_idle_q   <= 1'b1;
			started_q   <= 1'b0;
			resched_q   <= 1'b0;
			tick_q      <= '0;
			rd_vld_s1   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			running_q   <= running_d;
			on_idle_q   <= on_idle_d;
			started_q   <= started_d;
			resched_q   <= resched_d;
			tick_q      <= tick_d;
			rd_vld_s1   <= rd_vld_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tick_scan_q <= tick_scan_d;
		tgt_q       <= tgt_d;
		scan_addr_q <= scan_addr_d;
		scan_cnt_q  <= scan_cnt_d;
		rd_addr_s1  <= rd_addr_d;
		found_q     <= found_d;
		pick_q      <= pick_d;
		old_q       <= old_d;
		was_idle_q  <= was_idle_d;
		old_act_q   <= old_act_d;
		sw_q        <= sw_d;
		added_q     <= added_d;
		status_q    <= status_d;
		if (res_load) begin
			res_q.current_index      <= on_idle_q ? 4'd0 : run_w[3:0];
			res_q.idle_running       <= on_idle_q;
			res_q.switched           <= sw_q;
			res_q.reschedule_pending <= resched_q;
			res_q.added_index        <= added_q;
			res_q.status             <= status_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[src/round_robin_thread_scheduler.sv]
// Top level of the round-robin thread scheduler with sleep timers.
// Depends on rrts_pkg, rrts_front, rrts_back (and rrts_ram through it).
//
//   Channel   Handshake           Fields
//   request   push / full         req_type, thread_index, sleep_ticks
//   result    empty / pop         current_index, idle_running, switched,
//                                 reschedule_pending, added_index, status
//
// Add, start, bad requests and failed checks other than wake's go straight to
// the result; wake first reads the target's state. Yield, yield-if-pending,
// block, sleep and finish walk the whole state table one entry a cycle once
// started. A tick walks both tables the same way; the two tables share one
// read address. Reset is asynchronous and needs no clearing pass. The
// two-entry request queue keeps taking transfers while a result waits to be
// popped.
module round_robin_thread_scheduler #(
	parameter int MAX_THREADS = 16,
	parameter int TICK_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [3:0]  req_type,
	input  logic [3:0]  thread_index,
	input  logic [31:0] sleep_ticks,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  current_index,
	output logic        idle_running,
	output logic        switched,
	output logic        reschedule_pending,
	output logic [3:0]  added_index,
	output logic [1:0]  status
);

	logic           cmd_valid;
	rrts_pkg::cmd_t cmd;
	logic           cmd_pop;
	logic           res_valid;
	rrts_pkg::res_t res;

	rrts_front #(.MAX_THREADS(MAX_THREADS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.thread_index (thread_index),
		.sleep_ticks  (sleep_ticks),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	rrts_back #(
		.MAX_THREADS (MAX_THREADS),
		.TICK_BITS   (TICK_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (pop)
	);

	assign empty              = !res_valid;
	assign current_index      = res.current_index;
	assign idle_running       = res.idle_running;
	assign switched           = res.switched;
	assign reschedule_pending = res.reschedule_pending;
	assign added_index        = res.added_index;
	assign status             = res.status;

endmodule
